// ----- sv/bpd_pkg.sv -----
// shared constants and types for the block pooling downsampler
package bpd_pkg;

  localparam int ACC_DEPTH   = 512;
  localparam int ACC_AW      = $clog2(ACC_DEPTH);
  localparam int SAMPLE_BITS = 32;
  localparam int ACC_W       = 64;
  localparam int CNT_W       = 32;

  localparam logic [9:0] MAX_FIT_WIDTH  = 10'd512;
  localparam logic [9:0] MAX_FIT_HEIGHT = 10'd512;

  localparam logic [2:0] REG_N_SPECTRA  = 3'd0;
  localparam logic [2:0] REG_N_BINS     = 3'd1;
  localparam logic [2:0] REG_FIT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FIT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_POOL_MODE  = 3'd4;

  localparam logic POOL_AVG = 1'b0;
  localparam logic POOL_MAX = 1'b1;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  num;
    logic [CNT_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ACC_W-1:0]  quo;
  } div_rsp_t;

endpackage

// ----- sv/block_pooling_downsampler_unit.sv -----
// block pooling downsampler top level: control, position tracking, output register
//
//  channel   signals                                          direction
//  sample    sample_valid, sample_stall, sample               in
//  result    result_valid, result_stall, pooled_value,
//            block_col, block_row, frame_done                 out
//  config    cfg_we, cfg_index, cfg_data                      in
//
// each sample is read from the accumulator, then modified and written back;
// a sample that closes a max block then passes S_MX and S_OUT, one that closes
// an average block S_DS, S_DW (the divider) and S_OUT; sample_stall stays high
// until idle. a register write recomputes both strides on the same divider, also stalled.
// reset sets 512 x 512 with stride 1 and needs no sweep of the memory.
// a stalled result waits in the output register; the next sample is taken then.
module block_pooling_downsampler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [31:0] sample,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] pooled_value,
  output logic [8:0]  block_col,
  output logic [8:0]  block_row,
  output logic        frame_done,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CS   = 10'b0000000010,
    S_CW   = 10'b0000000100,
    S_RS   = 10'b0000001000,
    S_RW   = 10'b0000010000,
    S_UPD  = 10'b0000100000,
    S_DS   = 10'b0001000000,
    S_DW   = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_MX   = 10'b1000000000
  } state_t;

  state_t state;

  logic [15:0] n_spectra, n_bins;
  logic [9:0]  fit_width, fit_height;
  logic        pool_mode;
  logic [15:0] col_stride, row_stride;

  logic [15:0] sp, bp, cin, rin, bx, by, x0, y0;

  // per sample latches
  logic [31:0]                s_r;
  logic [bpd_pkg::ACC_AW-1:0] idx_r;
  logic                       first_r, emit_r, fend_r;
  logic [8:0]                 bx_r, by_r;
  logic [15:0]                w_r, h_r;
  logic [bpd_pkg::ACC_W-1:0]  val_r;
  logic [bpd_pkg::CNT_W-1:0]  cnt_r;

  logic [15:0] ns_eff, nb_eff;
  logic [9:0]  fw_eff, fh_eff;
  logic        accept, sp_end, bp_end, col_last, row_last, frame_end;
  logic [15:0] rem_c, rem_r, w, h;
  logic [31:0] s_masked;

  logic [bpd_pkg::ACC_W-1:0] rdata, acc_new;
  logic [bpd_pkg::ACC_W:0]   sum;

  bpd_pkg::div_req_t div_req;
  bpd_pkg::div_rsp_t div_rsp;

  assign ns_eff = (n_spectra == 16'd0) ? 16'd1 : n_spectra;
  assign nb_eff = (n_bins == 16'd0) ? 16'd1 : n_bins;
  assign fw_eff = (fit_width == 10'd0) ? 10'd1 :
                  (fit_width > bpd_pkg::MAX_FIT_WIDTH) ? bpd_pkg::MAX_FIT_WIDTH : fit_width;
  assign fh_eff = (fit_height == 10'd0) ? 10'd1 :
                  (fit_height > bpd_pkg::MAX_FIT_HEIGHT) ? bpd_pkg::MAX_FIT_HEIGHT : fit_height;

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;

  assign sp_end    = ({1'b0, sp} + 17'd1) >= {1'b0, ns_eff};
  assign bp_end    = ({1'b0, bp} + 17'd1) >= {1'b0, nb_eff};
  assign col_last  = (({1'b0, cin} + 17'd1) == {1'b0, col_stride}) || sp_end;
  assign row_last  = (({1'b0, rin} + 17'd1) == {1'b0, row_stride}) || bp_end;
  assign frame_end = sp_end && bp_end;
  assign rem_c     = ns_eff - x0;
  assign rem_r     = nb_eff - y0;
  assign w         = (col_stride < rem_c) ? col_stride : rem_c;
  assign h         = (row_stride < rem_r) ? row_stride : rem_r;
  assign s_masked  = sample & 32'((64'd1 << bpd_pkg::SAMPLE_BITS) - 64'd1);

  // read-modify-write of the row accumulator
  assign sum = {1'b0, rdata} + {33'd0, s_r};
  always_comb begin
    if (first_r) begin
      acc_new = {32'd0, s_r};
    end else if (pool_mode == bpd_pkg::POOL_MAX) begin
      acc_new = ({32'd0, s_r} > rdata) ? {32'd0, s_r} : rdata;
    end else begin
      acc_new = sum[bpd_pkg::ACC_W] ? '1 : sum[bpd_pkg::ACC_W-1:0];
    end
  end

  bpd_mem u_mem (
    .clk   (clk),
    .we    (state == S_UPD),
    .waddr (idx_r),
    .wdata (acc_new),
    .re    (accept),
    .raddr (by[bpd_pkg::ACC_AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    div_req.start = (state == S_CS) || (state == S_RS) || (state == S_DS);
    unique case (state)
      S_CS: begin
        div_req.num = {47'd0, {1'b0, ns_eff} + {7'd0, fw_eff} - 17'd1};
        div_req.den = {22'd0, fw_eff};
      end
      S_RS: begin
        div_req.num = {47'd0, {1'b0, nb_eff} + {7'd0, fh_eff} - 17'd1};
        div_req.den = {22'd0, fh_eff};
      end
      default: begin
        div_req.num = val_r;
        div_req.den = cnt_r;
      end
    endcase
  end

  bpd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      n_spectra    <= 16'd512;
      n_bins       <= 16'd512;
      fit_width    <= 10'd512;
      fit_height   <= 10'd512;
      pool_mode    <= bpd_pkg::POOL_AVG;
      col_stride   <= 16'd1;
      row_stride   <= 16'd1;
      sp <= '0; bp <= '0; cin <= '0; rin <= '0;
      bx <= '0; by <= '0; x0 <= '0; y0 <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end

      // a register write restarts the frame and recomputes the strides
      if (cfg_we && (cfg_index <= bpd_pkg::REG_POOL_MODE)) begin
        case (cfg_index)
          bpd_pkg::REG_N_SPECTRA:  n_spectra  <= cfg_data;
          bpd_pkg::REG_N_BINS:     n_bins     <= cfg_data;
          bpd_pkg::REG_FIT_WIDTH:  fit_width  <= cfg_data[9:0];
          bpd_pkg::REG_FIT_HEIGHT: fit_height <= cfg_data[9:0];
          default:                 pool_mode  <= cfg_data[0];
        endcase
        sp <= '0; bp <= '0; cin <= '0; rin <= '0;
        bx <= '0; by <= '0; x0 <= '0; y0 <= '0;
        state <= S_CS;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (accept) begin
              s_r     <= s_masked;
              idx_r   <= by[bpd_pkg::ACC_AW-1:0];
              first_r <= (cin == 16'd0) && (rin == 16'd0);
              emit_r  <= col_last && row_last;
              fend_r  <= frame_end;
              bx_r    <= bx[8:0];
              by_r    <= by[8:0];
              w_r     <= w;
              h_r     <= h;
              state   <= S_UPD;
              if (frame_end) begin
                sp <= '0; bp <= '0; cin <= '0; rin <= '0;
                bx <= '0; by <= '0; x0 <= '0; y0 <= '0;
              end else if (bp_end) begin
                bp  <= '0; rin <= '0; by <= '0; y0 <= '0;
                sp  <= sp + 16'd1;
                if (col_last) begin
                  cin <= '0;
                  bx  <= bx + 16'd1;
                  x0  <= x0 + col_stride;
                end else begin
                  cin <= cin + 16'd1;
                end
              end else begin
                bp <= bp + 16'd1;
                if (row_last) begin
                  rin <= '0;
                  by  <= by + 16'd1;
                  y0  <= y0 + row_stride;
                end else begin
                  rin <= rin + 16'd1;
                end
              end
            end
          end
          S_CS: state <= S_CW;
          S_CW: begin
            if (div_rsp.done) begin
              col_stride <= div_rsp.quo[15:0];
              state      <= S_RS;
            end
          end
          S_RS: state <= S_RW;
          S_RW: begin
            if (div_rsp.done) begin
              row_stride <= div_rsp.quo[15:0];
              state      <= S_IDLE;
            end
          end
          S_UPD: begin
            val_r <= acc_new;
            cnt_r <= w_r * h_r;
            if (!emit_r) begin
              state <= S_IDLE;
            end else if (pool_mode == bpd_pkg::POOL_MAX) begin
              state <= S_MX;
            end else begin
              state <= S_DS;
            end
          end
          S_MX: state <= S_OUT;
          S_DS: state <= S_DW;
          S_DW: begin
            if (div_rsp.done) begin
              val_r <= div_rsp.quo;
              state <= S_OUT;
            end
          end
          S_OUT: begin
            if (!result_valid || !result_stall) begin
              result_valid <= 1'b1;
              pooled_value <= (val_r[63:32] != 32'd0) ? 32'hFFFF_FFFF : val_r[31:0];
              block_col    <= bx_r;
              block_row    <= by_r;
              frame_done   <= fend_r;
              state        <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// ----- sv/bpd_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module bpd_div (
  input  logic              clk,
  input  logic              rst,
  input  bpd_pkg::div_req_t req,
  output bpd_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(bpd_pkg::ACC_W + 1);

  logic                        run;
  logic [CW-1:0]               cnt;
  logic [bpd_pkg::CNT_W-1:0]   rem;
  logic [bpd_pkg::ACC_W-1:0]   quo;
  logic [bpd_pkg::CNT_W-1:0]   den;
  logic                        done;
  logic [bpd_pkg::CNT_W:0]     trial;
  logic                        fits;

  assign trial = {rem, quo[bpd_pkg::ACC_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CW'(bpd_pkg::ACC_W);
        rem <= '0;
        quo <= req.num;
        den <= req.den;
      end else if (run) begin
        rem <= fits ? bpd_pkg::CNT_W'(trial - {1'b0, den}) : bpd_pkg::CNT_W'(trial);
        quo <= {quo[bpd_pkg::ACC_W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

// ----- sv/bpd_mem.sv -----
// per-row accumulator memory, one write and one registered read port
module bpd_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bpd_pkg::ACC_AW-1:0] waddr,
  input  logic [bpd_pkg::ACC_W-1:0]  wdata,
  input  logic                       re,
  input  logic [bpd_pkg::ACC_AW-1:0] raddr,
  output logic [bpd_pkg::ACC_W-1:0]  rdata
);

  logic [bpd_pkg::ACC_W-1:0] mem [bpd_pkg::ACC_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bpd_checker.sv -----
// port level checks for the block pooling downsampler, bound to the top level
module bpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] pooled_value,
  input logic        cfg_we,
  input logic [2:0]  cfg_index
);

  // one request at a time: the block is busy right after taking a sample
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while previous request still in flight");

  // a register write launches the stride recompute
  a_busy_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index <= bpd_pkg::REG_POOL_MODE) |=> sample_stall)
    else $error("sample channel open during stride recompute");

  // no result appears in the cycle right after a sample is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && !result_valid |=> !result_valid)
    else $error("result produced without accumulator update");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(pooled_value))
    else $error("stalled result dropped or changed");

endmodule

bind block_pooling_downsampler_unit bpd_checker u_bpd_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .pooled_value (pooled_value),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index)
);
